### design/dmt_pkg.sv
// ----------------------------------------------------------------------------
// dmt_pkg
// Shared field widths, result codes and the scan token of the diagonal
// match table.
// ----------------------------------------------------------------------------
package dmt_pkg;

    localparam int IN_POS_W  = 31;
    localparam int ENTRIES_W = 5;
    localparam int DIST_W    = 21;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_BIAS  = 24;

    localparam logic [COUNT_W-1:0] HIT_MAX = 16'hFFFF;

    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ADDED_ROOM = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXTENDED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DISTANCE = 2'd1;

    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd8;
    localparam logic [DIST_W-1:0]    DIST_RESET    = 21'd1024;

    // Scan state carried from cell to cell. room_cnt saturates at two.
    typedef struct packed {
        logic       valid;
        logic       extended;
        logic       have_pick;
        logic       have_next;
        logic       pick_live;
        logic [1:0] room_cnt;
    } dmt_token_t;

endpackage

### design/dmt_cell.sv
// ----------------------------------------------------------------------------
// dmt_cell
// One table entry. Updates the passing scan token with this entry's verdict
// and extends its own run on a diagonal hit.
// ----------------------------------------------------------------------------
module dmt_cell #(
    parameter int POS_W    = 32,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         active,
    input  logic                         clear,
    input  logic                         fill,
    input  logic [POS_W-1:0]             o,
    input  logic [POS_W-1:0]             n,
    input  logic [dmt_pkg::IN_POS_W-1:0] base,
    input  logic [dmt_pkg::DIST_W-1:0]   match_dist,
    input  dmt_pkg::dmt_token_t          tok_in,
    input  logic [IDX_W-1:0]             pick_in,
    input  logic [POS_W-1:0]             pick_new_in,
    output dmt_pkg::dmt_token_t          tok_out,
    output logic [IDX_W-1:0]             pick_out,
    output logic [POS_W-1:0]             pick_new_out
);
    import dmt_pkg::*;

    localparam int CMP_W = ((POS_W > IN_POS_W) ? POS_W : IN_POS_W) + 2;
    localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(CELL_IDX);

    logic [COUNT_W-1:0] count_reg;
    logic [POS_W-1:0]   last_orig_reg;
    logic [POS_W-1:0]   last_new_reg;
    logic [POS_W-1:0]   run_begin_reg;

    dmt_token_t         tok_reg, tok_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [POS_W-1:0]   pnew_reg, pnew_next;

    logic signed [CMP_W-1:0] so, sn, slo, sln, srb, spn, sbase, sdist;
    logic signed [CMP_W-1:0] new_last;
    logic live, diag_eq, in_window, stale, older, n_beyond, ext_here, post_stale, room_add;

    always_comb
    begin
        so    = {{(CMP_W-POS_W){o[POS_W-1]}}, o};
        sn    = {{(CMP_W-POS_W){n[POS_W-1]}}, n};
        slo   = {{(CMP_W-POS_W){last_orig_reg[POS_W-1]}}, last_orig_reg};
        sln   = {{(CMP_W-POS_W){last_new_reg[POS_W-1]}}, last_new_reg};
        srb   = {{(CMP_W-POS_W){run_begin_reg[POS_W-1]}}, run_begin_reg};
        spn   = {{(CMP_W-POS_W){pick_new_in[POS_W-1]}}, pick_new_in};
        sbase = {{(CMP_W-IN_POS_W){1'b0}}, base};
        sdist = {{(CMP_W-DIST_W){1'b0}}, match_dist};

        live      = (count_reg != '0);
        diag_eq   = ((so - slo) == (sn - sln));
        in_window = (sn <= sln + sdist) && (sn + sdist >= srb);
        stale     = (sln < sbase);
        older     = (sln < spn);
        n_beyond  = (sn > sln);
        new_last  = n_beyond ? sn : sln;
        post_stale = (new_last < sbase);
        ext_here  = active && tok_in.valid && !tok_in.extended && live
                    && diag_eq && in_window;
    end

    always_comb
    begin
        tok_next  = tok_in;
        pick_next = pick_in;
        pnew_next = pick_new_in;
        room_add  = 1'b0;
        if (active && tok_in.valid)
        begin
            if (!tok_in.extended)
            begin
                if (!live)
                begin
                    // An empty entry displaces any stale choice.
                    if (!tok_in.have_pick || tok_in.pick_live)
                    begin
                        tok_next.have_next = tok_in.have_pick;
                        tok_next.have_pick = 1'b1;
                        tok_next.pick_live = 1'b0;
                        pick_next          = CELL_ID;
                    end
                    else
                    begin
                        tok_next.have_next = 1'b1;
                    end
                end
                else if (ext_here)
                begin
                    tok_next.extended = 1'b1;
                    pick_next         = CELL_ID;
                end
                else if (stale)
                begin
                    if (!tok_in.have_pick || (tok_in.pick_live && older))
                    begin
                        tok_next.have_next = tok_in.have_pick;
                        tok_next.have_pick = 1'b1;
                        tok_next.pick_live = 1'b1;
                        pick_next          = CELL_ID;
                        pnew_next          = last_new_reg;
                    end
                    else
                    begin
                        tok_next.have_next = 1'b1;
                    end
                end
            end
            // The extended entry counts with its updated position.
            room_add = ext_here ? post_stale : (!live || stale);
            if (room_add && (tok_in.room_cnt != 2'd2))
            begin
                tok_next.room_cnt = tok_in.room_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (clear)
            begin
                count_reg <= '0;
            end
            else if (fill)
            begin
                count_reg <= COUNT_W'(1);
            end
            else if (ext_here && (count_reg != HIT_MAX))
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        pnew_reg <= pnew_next;
        if (fill)
        begin
            last_orig_reg <= o;
            last_new_reg  <= n;
            run_begin_reg <= n;
        end
        else if (ext_here)
        begin
            if (n_beyond)
            begin
                last_new_reg  <= n;
                last_orig_reg <= o;
            end
            else if (sn < srb)
            begin
                run_begin_reg <= n;
            end
        end
    end

    assign tok_out      = tok_reg;
    assign pick_out     = pick_reg;
    assign pick_new_out = pnew_reg;

endmodule

### design/diagonal_match_table_insert.sv
// ----------------------------------------------------------------------------
// diagonal_match_table_insert
// Table of diff match runs: extends a run on the same diagonal or opens a
// new one in an empty or stale entry, built as a chain of entry cells.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  input     in_valid/in_ready, op, orig_pos, new_pos,     in
//            base_pos
//  result    out_valid/out_ready, status, slot, room_left  out
//  config    cfg_valid/cfg_ready, cfg_index, cfg_data      in
//
// An add transaction sends a token down the cell chain, one cell a cycle; the
// result is captured when the token leaves the last cell, and the next input
// is taken only back in idle. A clear skips the scan and goes straight to FIN.
// Reset empties the table and loads entries_used = 8, match_distance = 1024.
// A result waiting on out_ready holds the block in its final state; the input
// is accepted again once the result has moved into the output register.
module diagonal_match_table_insert #(
    parameter int MAX_ENTRIES = 16,
    parameter int POS_WIDTH   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [dmt_pkg::IN_POS_W-1:0]   orig_pos,
    input  logic [dmt_pkg::IN_POS_W-1:0]   new_pos,
    input  logic [dmt_pkg::IN_POS_W-1:0]   base_pos,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dmt_pkg::STATUS_W-1:0]   status,
    output logic [dmt_pkg::SLOT_W-1:0]     slot,
    output logic                           room_left,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dmt_pkg::DIST_W-1:0]     cfg_data
);
    import dmt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W = ((POS_WIDTH > IN_POS_W) ? POS_WIDTH : IN_POS_W) + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [ENTRIES_W-1:0]   entries_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   launch_reg;
    logic [POS_WIDTH-1:0]   o_reg, n_reg;
    logic [IN_POS_W-1:0]    base_reg;
    logic [STATUS_W-1:0]    pend_status_reg;
    logic [SLOT_W-1:0]      pend_slot_reg;
    logic                   pend_room_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   room_reg;
    logic                   out_valid_reg;

    dmt_token_t             tok_chain  [MAX_ENTRIES+1];
    logic [IDX_W-1:0]       pick_chain [MAX_ENTRIES+1];
    logic [POS_WIDTH-1:0]   pnew_chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] cell_active;
    logic [MAX_ENTRIES-1:0] cell_fill;

    logic in_accept, clear_now, tail_done, fill_now, n_lt_base, out_load;
    logic signed [CMP_W-1:0] sn, sbase;
    dmt_token_t tail;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign clear_now = in_accept && op;

    assign tail      = tok_chain[MAX_ENTRIES];
    assign tail_done = (state_reg == S_SCAN) && tail.valid;
    assign fill_now  = tail_done && !tail.extended && tail.have_pick;
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        sn        = {{(CMP_W-POS_WIDTH){n_reg[POS_WIDTH-1]}}, n_reg};
        sbase     = {{(CMP_W-IN_POS_W){1'b0}}, base_reg};
        n_lt_base = (sn < sbase);
    end

    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = launch_reg;
        pick_chain[0]      = '0;
        pnew_chain[0]      = '0;
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        assign cell_active[i] = (int'(entries_reg) > i);
        assign cell_fill[i]   = fill_now && (pick_chain[MAX_ENTRIES] == IDX_W'(i));

        dmt_cell #(
            .POS_W    (POS_WIDTH),
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .active       (cell_active[i]),
            .clear        (clear_now),
            .fill         (cell_fill[i]),
            .o            (o_reg),
            .n            (n_reg),
            .base         (base_reg),
            .match_dist   (dist_reg),
            .tok_in       (tok_chain[i]),
            .pick_in      (pick_chain[i]),
            .pick_new_in  (pnew_chain[i]),
            .tok_out      (tok_chain[i+1]),
            .pick_out     (pick_chain[i+1]),
            .pick_new_out (pnew_chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = op ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (tail_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= ENTRIES_RESET;
            dist_reg      <= DIST_RESET;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= in_accept && !op;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_ENTRIES_USED:   entries_reg <= cfg_data[ENTRIES_W-1:0];
                    CFG_MATCH_DISTANCE: dist_reg    <= cfg_data;
                    default:            ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            o_reg    <= POS_WIDTH'(orig_pos) - POS_WIDTH'(POS_BIAS);
            n_reg    <= POS_WIDTH'(new_pos) - POS_WIDTH'(POS_BIAS);
            base_reg <= base_pos;
        end
        if (clear_now)
        begin
            pend_status_reg <= ST_CLEARED;
            pend_slot_reg   <= '0;
            pend_room_reg   <= (entries_reg != '0);
        end
        else if (tail_done)
        begin
            if (tail.extended)
            begin
                pend_status_reg <= ST_EXTENDED;
                pend_slot_reg   <= SLOT_W'(pick_chain[MAX_ENTRIES]);
                pend_room_reg   <= (tail.room_cnt != 2'd0);
            end
            else if (tail.have_pick)
            begin
                pend_status_reg <= tail.have_next ? ST_ADDED_ROOM : ST_ADDED_FULL;
                pend_slot_reg   <= SLOT_W'(pick_chain[MAX_ENTRIES]);
                // The chosen entry was counted as free before it was written.
                pend_room_reg   <= (tail.room_cnt == 2'd2) || n_lt_base;
            end
            else
            begin
                pend_status_reg <= ST_REJECTED;
                pend_slot_reg   <= '0;
                pend_room_reg   <= (tail.room_cnt != 2'd0);
            end
        end
        if (out_load)
        begin
            status_reg <= pend_status_reg;
            slot_reg   <= pend_slot_reg;
            room_reg   <= pend_room_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign room_left = room_reg;

endmodule

### tb/sv/diagonal_match_table_insert_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// diagonal_match_table_insert_tb
// Self-checking bench for the diff match-run table. Hits and clears go in
// through the input handshake and an internal model of the table predicts
// each result. The run steps through several table sizes and match windows,
// mostly with hits that follow a few diagonals so that runs get extended,
// entries go stale and the table fills up.
// ----------------------------------------------------------------------------
module diagonal_match_table_insert_tb;

    import dmt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int POS_W        = 32;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int PRINT_LIMIT  = 40;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [IN_POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic                op;
        logic [IN_POS_W-1:0] orig_pos;
        logic [IN_POS_W-1:0] new_pos;
        logic [IN_POS_W-1:0] base_pos;
    } hit_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                room_left;
    } insert_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 op        = OP_ADD;
    logic [IN_POS_W-1:0]  orig_pos  = '0;
    logic [IN_POS_W-1:0]  new_pos   = '0;
    logic [IN_POS_W-1:0]  base_pos  = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic                 room_left;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENTRIES_USED;
    logic [DIST_W-1:0]    cfg_data  = '0;

    // Model of the table and its registers.
    logic [ENTRIES_W-1:0]    cur_entries  = ENTRIES_RESET;
    logic [DIST_W-1:0]       cur_distance = DIST_RESET;
    logic [COUNT_W-1:0]      run_hits      [TABLE_DEPTH] = '{default: '0};
    logic signed [POS_W-1:0] run_last_orig [TABLE_DEPTH] = '{default: '0};
    logic signed [POS_W-1:0] run_last_new  [TABLE_DEPTH] = '{default: '0};
    logic signed [POS_W-1:0] run_start     [TABLE_DEPTH] = '{default: '0};

    hit_item_t      pending_items[$];
    insert_result_t expected_results[$];
    hit_item_t      next_item;
    insert_result_t oldest_result;

    bit in_fire     = 1'b0;
    bit idling_on   = 1'b1;
    int send_gap    = 0;
    int recv_gap    = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;

    diagonal_match_table_insert #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .POS_WIDTH   (POS_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .orig_pos  (orig_pos),
        .new_pos   (new_pos),
        .base_pos  (base_pos),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .slot      (slot),
        .room_left (room_left),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // Applies one add or clear to the table model and returns its result.
    function automatic insert_result_t table_insert(logic is_clear,
                                                    logic [IN_POS_W-1:0] orig_in,
                                                    logic [IN_POS_W-1:0] new_in,
                                                    logic [IN_POS_W-1:0] base_in);
        insert_result_t res;
        logic signed [POS_W-1:0] o_w, n_w;
        longint base, o, n, window, lo, ln, rb;
        int lim, pick;
        bit have_pick, have_next, extended;
        res       = '0;
        base      = longint'(base_in);
        lim       = (cur_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_entries);
        have_pick = 1'b0;
        have_next = 1'b0;
        extended  = 1'b0;
        pick      = 0;
        if (is_clear == OP_CLEAR)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                run_hits[i]      = '0;
                run_last_orig[i] = '0;
                run_last_new[i]  = '0;
                run_start[i]     = '0;
            end
            res.status = ST_CLEARED;
        end
        else
        begin
            o_w    = {1'b0, orig_in} - POS_BIAS;
            n_w    = {1'b0, new_in} - POS_BIAS;
            o      = longint'(o_w);
            n      = longint'(n_w);
            window = longint'(cur_distance);
            for (int i = 0; i < lim; i++)
            begin
                lo = longint'(run_last_orig[i]);
                ln = longint'(run_last_new[i]);
                rb = longint'(run_start[i]);
                if (run_hits[i] == 0)
                begin
                    if (!have_pick || run_hits[pick] != 0)
                    begin
                        have_next = have_pick;
                        have_pick = 1'b1;
                        pick      = i;
                    end
                    else
                        have_next = 1'b1;
                end
                else if (o - lo == n - ln && n <= ln + window && n + window >= rb)
                begin
                    if (run_hits[i] != HIT_MAX)
                        run_hits[i]++;
                    if (n > ln)
                    begin
                        run_last_new[i]  = n_w;
                        run_last_orig[i] = o_w;
                    end
                    else if (n < rb)
                        run_start[i] = n_w;
                    res.slot = i[SLOT_W-1:0];
                    extended = 1'b1;
                    break;
                end
                else if (ln < base)
                begin
                    // A stale entry only displaces a choice that is itself
                    // stale and more recent.
                    if (!have_pick || (run_hits[pick] != 0 &&
                                       ln < longint'(run_last_new[pick])))
                    begin
                        have_next = have_pick;
                        have_pick = 1'b1;
                        pick      = i;
                    end
                    else
                        have_next = 1'b1;
                end
            end
            if (extended)
                res.status = ST_EXTENDED;
            else if (!have_pick)
                res.status = ST_REJECTED;
            else
            begin
                run_last_orig[pick] = o_w;
                run_last_new[pick]  = n_w;
                run_start[pick]     = n_w;
                run_hits[pick]      = 1;
                res.slot   = pick[SLOT_W-1:0];
                res.status = have_next ? ST_ADDED_ROOM : ST_ADDED_FULL;
            end
        end
        for (int i = 0; i < lim; i++)
            if (run_hits[i] == 0 || longint'(run_last_new[i]) < base)
                res.room_left = 1'b1;
        return res;
    endfunction

    // Input driver: presents queued transactions, with random gaps between them.
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                in_valid <= 1'b1;
                op       <= next_item.op;
                orig_pos <= next_item.orig_pos;
                new_pos  <= next_item.new_pos;
                base_pos <= next_item.base_pos;
                if (idling_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (recv_gap != 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: follows register writes and inputs, checks every result.
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ENTRIES_USED)
                    cur_entries = cfg_data[ENTRIES_W-1:0];
                else if (cfg_index == CFG_MATCH_DISTANCE)
                    cur_distance = cfg_data;
            end
            if (in_fire)
                expected_results.push_back(table_insert(op, orig_pos, new_pos, base_pos));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result arrived with no transaction outstanding");
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  status, oldest_result.status));
                    if (slot !== oldest_result.slot)
                        report_mismatch($sformatf("slot %0d, predicted %0d",
                                                  slot, oldest_result.slot));
                    if (room_left !== oldest_result.room_left)
                        report_mismatch($sformatf("room_left %b, predicted %b",
                                                  room_left, oldest_result.room_left));
                end
            end
            if (in_fire || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic queue_hit(logic is_clear, logic [IN_POS_W-1:0] o,
                             logic [IN_POS_W-1:0] n, logic [IN_POS_W-1:0] b);
        hit_item_t item;
        item.op       = is_clear;
        item.orig_pos = o;
        item.new_pos  = n;
        item.base_pos = b;
        pending_items.push_back(item);
    endtask

    function automatic logic [IN_POS_W-1:0] noisy_pos();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return POS_MAX;
            2: return IN_POS_W'(POS_BIAS);
            3: return IN_POS_W'(POS_BIAS - 1);
            default: return IN_POS_W'($urandom);
        endcase
    endfunction

    // Mostly hits that walk along a handful of diagonals, so runs get
    // extended in both directions, age out behind base and fill the table.
    task automatic queue_hits(int count, int distance);
        logic [IN_POS_W-1:0] cursor, new_p, orig_p, base_p;
        logic [IN_POS_W-1:0] diagonals [6];
        int unsigned roll, pick, span;
        span   = distance + 1;
        cursor = IN_POS_W'($urandom);
        foreach (diagonals[d])
            diagonals[d] = IN_POS_W'($urandom_range(0, 1 << 20));
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                queue_hit(OP_CLEAR, IN_POS_W'($urandom), IN_POS_W'($urandom),
                          IN_POS_W'($urandom));
            else if (roll < 15)
                queue_hit(OP_ADD, noisy_pos(), noisy_pos(), noisy_pos());
            else
            begin
                pick = $urandom_range(0, 5);
                if (roll < 30)
                    diagonals[pick] = IN_POS_W'($urandom);
                cursor = cursor + IN_POS_W'($urandom_range(0, span / 4 + 1));
                new_p  = cursor + IN_POS_W'($urandom_range(0, span)) - IN_POS_W'(span / 2);
                orig_p = new_p + diagonals[pick];
                if (roll < 40)
                    base_p = '0;
                else
                    base_p = cursor - IN_POS_W'($urandom_range(0, 3 * span + 16));
                queue_hit(OP_ADD, orig_p, new_p, base_p);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits for the table to go quiet, then reprograms it and queues traffic.
    task automatic run_phase(int entries, int distance, int count, bit with_idle);
        logic [DIST_W-1:0] entries_word;
        wait_drained();
        idling_on = with_idle;
        // Upper data bits are don't-care for the entry count.
        entries_word = DIST_W'($urandom);
        entries_word[ENTRIES_W-1:0] = entries[ENTRIES_W-1:0];
        write_reg(CFG_ENTRIES_USED, entries_word);
        write_reg(CFG_MATCH_DISTANCE, distance[DIST_W-1:0]);
        queue_hits(count, distance);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass with the reset settings: 8 entries, window 1024.
        queue_hit(OP_ADD, 0, 0, 0);
        queue_hit(OP_ADD, 0, 0, 0);
        queue_hit(OP_ADD, 10, 10, 0);
        queue_hit(OP_ADD, 5000, 3000, 0);
        queue_hit(OP_ADD, 4990, 2990, 0);
        queue_hit(OP_ADD, 4000, 2000, 0);
        queue_hit(OP_ADD, 2800, 800, 0);
        queue_hit(OP_ADD, POS_MAX, POS_MAX, 0);
        queue_hit(OP_ADD, POS_MAX, 0, 0);
        queue_hit(OP_ADD, 0, POS_MAX, 0);
        queue_hit(OP_ADD, 900000, 100, 0);
        queue_hit(OP_ADD, 800000, 200, 0);
        queue_hit(OP_ADD, 123456, 7, 0);
        queue_hit(OP_ADD, 99, 5, 5000);
        queue_hit(OP_ADD, 77, 9, POS_MAX);
        queue_hit(OP_ADD, 70000, 60000, POS_MAX);
        queue_hit(OP_CLEAR, POS_MAX, POS_MAX, POS_MAX);
        queue_hit(OP_ADD, 24, 24, 1);
        queue_hit(OP_ADD, 23, 25, 0);
        queue_hit(OP_ADD, 24, 24, 0);
        queue_hit(OP_CLEAR, 0, 0, 0);

        run_phase(16, 1024, 260, 1'b1);
        run_phase(1, 0, 120, 1'b1);
        run_phase(4, 2097151, 220, 1'b1);
        run_phase(0, 700, 40, 1'b1);
        run_phase(31, 300, 240, 1'b1);
        run_phase(8, 1048576, 220, 1'b1);
        run_phase(2, 16, 150, 1'b1);
        run_phase($urandom_range(5, 16), $urandom_range(0, 4095), 200, 1'b1);
        run_phase(12, 2000, 280, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
design/dmt_pkg.sv
design/dmt_cell.sv
design/diagonal_match_table_insert.sv
tb/sv/diagonal_match_table_insert_tb.sv
